// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of the message queue.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is ignored while reset is high.
`define TLPMQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tlpmq assertion failed");

// Assertion that is also checked during reset.
`define TLPMQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tlpmq assertion failed");

`endif

// ===== rtl/core/tlpmq_pkg.sv =====
// Types, sizes and codes for the three-level priority message queue.
// No dependencies.
`default_nettype none

package tlpmq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int NUM_LEVELS   = 3;

  localparam int IN_PAYLOAD_W  = 32;
  localparam int OUT_PAYLOAD_W = 32;
  localparam int LVL_W         = 2;
  localparam int STATUS_W      = 3;
  localparam int PTR_W         = $clog2(QUEUE_DEPTH);
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH     = NUM_LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W        = $clog2(MEM_DEPTH);

  typedef logic [LVL_W-1:0]        level_t;
  typedef logic [PTR_W-1:0]        ptr_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [PAYLOAD_BITS-1:0] payload_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } command_t;

  localparam level_t LVL_URGENT     = 2'd0;
  localparam level_t LVL_UPDATE     = 2'd1;
  localparam level_t LVL_BACKGROUND = 2'd2;
  localparam level_t LVL_INVALID    = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED    = 3'd0,
    ST_BAD_LEVEL = 3'd1,
    ST_FULL      = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // Storage access for one item.
  typedef struct packed {
    logic  wr_en;
    logic  rd_en;
    addr_t addr;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/tlpmq_req_if.sv =====
// Request channel of the message queue: valid/ready plus one command item.
// Depends on tlpmq_pkg.
`default_nettype none

interface tlpmq_req_if;
  import tlpmq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [LVL_W-1:0]        alert_level;
  logic [IN_PAYLOAD_W-1:0] message_payload;

  modport source (output valid, command, alert_level, message_payload, input ready);
  modport sink   (input valid, command, alert_level, message_payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tlpmq_rsp_if.sv =====
// Response channel of the message queue: valid/ready plus one result item.
// Depends on tlpmq_pkg.
`default_nettype none

interface tlpmq_rsp_if;
  import tlpmq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [LVL_W-1:0]         out_level;
  logic [OUT_PAYLOAD_W-1:0] out_payload;

  modport source (output valid, status, out_level, out_payload, input ready);
  modport sink   (input valid, status, out_level, out_payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tlpmq_ctrl.sv =====
// Queue bookkeeping: head/tail pointers and fill counts per level, priority
// pick for pops, status decode and storage access. Depends on tlpmq_pkg.
`default_nettype none

module tlpmq_ctrl import tlpmq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  logic     command,
  input  level_t   alert_level,
  output mem_ctl_t mem_ctl,
  output status_t  status,
  output level_t   pop_level
);

  ptr_t head [NUM_LEVELS];
  ptr_t tail [NUM_LEVELS];
  cnt_t count [NUM_LEVELS];

  logic   pop_found;
  level_t pop_q;
  level_t push_q;
  logic   is_pop;

  function automatic ptr_t advance(input ptr_t p);
    advance = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic addr_t slot_addr(input level_t q, input ptr_t p);
    slot_addr = ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
  endfunction

  // Highest-priority non-empty queue; urgent wins.
  always_comb begin
    pop_found = 1'b0;
    pop_q     = LVL_URGENT;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        pop_found = 1'b1;
        pop_q     = LVL_W'(i);
      end
    end
  end

  always_comb begin
    is_pop  = (command == CMD_POP);
    push_q  = (alert_level == LVL_INVALID) ? LVL_URGENT : alert_level;
    mem_ctl = '0;
    if (is_pop) begin
      mem_ctl.addr = slot_addr(pop_q, head[pop_q]);
      if (pop_found) begin
        status        = ST_POPPED;
        mem_ctl.rd_en = accept;
      end else begin
        status = ST_EMPTY;
      end
    end else begin
      mem_ctl.addr = slot_addr(push_q, tail[push_q]);
      if (alert_level == LVL_INVALID) begin
        status = ST_BAD_LEVEL;
      end else if (count[push_q] == CNT_W'(QUEUE_DEPTH)) begin
        status = ST_FULL;
      end else begin
        status        = ST_PUSHED;
        mem_ctl.wr_en = accept;
      end
    end
    pop_level = (status == ST_POPPED) ? pop_q : LVL_URGENT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else if (mem_ctl.wr_en) begin
      tail[push_q]  <= advance(tail[push_q]);
      count[push_q] <= count[push_q] + 1'b1;
    end else if (mem_ctl.rd_en) begin
      head[pop_q]  <= advance(head[pop_q]);
      count[pop_q] <= count[pop_q] - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tlpmq_store.sv =====
// Message storage for all three queues, one slot range per level, with a
// registered read port. Depends on tlpmq_pkg.
`default_nettype none

module tlpmq_store import tlpmq_pkg::*; (
  input  logic     clk,
  input  mem_ctl_t mem_ctl,
  input  payload_t wdata,
  output payload_t rdata
);

  payload_t mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[mem_ctl.addr] <= wdata;
    end
    if (mem_ctl.rd_en) begin
      rdata <= mem[mem_ctl.addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/three_level_priority_message_queue_top.sv =====
// Three-level strict-priority message queue, top level.
// Depends on tlpmq_pkg, tlpmq_req_if, tlpmq_rsp_if, tlpmq_ctrl, tlpmq_store.
//
//  channel | dir | fields
//  --------+-----+-------------------------------------------
//  req     | in  | command, alert_level, message_payload
//  rsp     | out | status, out_level, out_payload
//
// One item per cycle while req.ready is high; its result appears in the cycle after the transfer,
// when the registered read of the message storage delivers a popped payload.
// Reset clears pointers, fill counts and the result valid; storage is not swept.
// req.ready is high when no result waits or the waiting one is taken now.
// A stalled result holds its fields until transferred.
`default_nettype none

module three_level_priority_message_queue_top import tlpmq_pkg::*; (
  input logic        clk,
  input logic        rst,
  tlpmq_req_if.sink  req,
  tlpmq_rsp_if.source rsp
);

  mem_ctl_t mem_ctl;
  status_t  item_status;
  level_t   item_level;
  payload_t rdata;
  logic     accept;

  logic     rsp_valid;
  status_t  rsp_status;
  level_t   rsp_level;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  tlpmq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (req.command),
    .alert_level (req.alert_level),
    .mem_ctl     (mem_ctl),
    .status      (item_status),
    .pop_level   (item_level)
  );

  tlpmq_store u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .wdata   (PAYLOAD_BITS'(req.message_payload)),
    .rdata   (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= item_status;
      rsp_level  <= item_level;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.out_level   = rsp_level;
  assign rsp.out_payload = (rsp_status == ST_POPPED) ? OUT_PAYLOAD_W'(rdata) : '0;

endmodule

`default_nettype wire

// ===== rtl/core/tlpmq_checker.sv =====
// Port-level checks for the message queue top, attached by bind.
// Depends on tlpmq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tlpmq_checker import tlpmq_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     req_valid,
  input logic                     req_ready,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input logic [STATUS_W-1:0]      status,
  input logic [LVL_W-1:0]         out_level,
  input logic [OUT_PAYLOAD_W-1:0] out_payload
);

  `TLPMQ_ASSERT_ALWAYS(a_reset_clears_valid, clk, rst |=> !rsp_valid)
  // Each transfer in gives a result in the next cycle.
  `TLPMQ_ASSERT(a_result_follows, clk, rst, req_valid && req_ready |=> rsp_valid)
  `TLPMQ_ASSERT(a_stall_holds, clk, rst,
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(out_payload))
  `TLPMQ_ASSERT(a_status_known, clk, rst, rsp_valid |-> status <= ST_EMPTY)
  // Only a pop carries a level and payload.
  `TLPMQ_ASSERT(a_quiet_fields, clk, rst,
    rsp_valid && status != ST_POPPED |-> out_level == '0 && out_payload == '0)

endmodule

bind three_level_priority_message_queue_top tlpmq_checker u_tlpmq_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .out_level   (rsp.out_level),
  .out_payload (rsp.out_payload)
);

`default_nettype wire

// ===== verif/tb_three_level_priority_message_queue_top.sv =====
// Self-checking testbench for the three-level priority message queue.
// Drives push and pop transfers and tracks the three levels in a small scoreboard.
// Depends on tlpmq_pkg, tlpmq_req_if, tlpmq_rsp_if and the top level.
module tb_three_level_priority_message_queue_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tlpmq_pkg::*;

  localparam int HOLD_OFF_CYCLES = 160;
  localparam int PHASE_ITEMS     = 375;

  typedef struct {
    status_t                  status;
    level_t                   level;
    logic [OUT_PAYLOAD_W-1:0] payload;
  } queue_result_t;

  class priority_queue_tracker;
    payload_t      slots[NUM_LEVELS][QUEUE_DEPTH];
    ptr_t          head_ptr[NUM_LEVELS];
    ptr_t          tail_ptr[NUM_LEVELS];
    cnt_t          fill[NUM_LEVELS];
    queue_result_t awaited_results[$];
    int            errors;

    function new();
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_ptr[i] = '0;
        tail_ptr[i] = '0;
        fill[i]     = '0;
      end
      errors = 0;
    endfunction

    function ptr_t next_ptr(ptr_t p);
      if (p == ptr_t'(QUEUE_DEPTH - 1)) begin
        return '0;
      end
      return p + 1'b1;
    endfunction

    function int pending_count();
      return awaited_results.size();
    endfunction

    // Works out the result of one accepted request and queues it.
    function void note_request(logic cmd, level_t lvl, logic [IN_PAYLOAD_W-1:0] data);
      queue_result_t r;
      r.status  = ST_EMPTY;
      r.level   = '0;
      r.payload = '0;
      if (cmd == CMD_PUSH) begin
        if (lvl == LVL_INVALID) begin
          r.status = ST_BAD_LEVEL;
        end else if (fill[lvl] == cnt_t'(QUEUE_DEPTH)) begin
          r.status = ST_FULL;
        end else begin
          slots[lvl][tail_ptr[lvl]] = payload_t'(data);
          tail_ptr[lvl] = next_ptr(tail_ptr[lvl]);
          fill[lvl]     = fill[lvl] + 1'b1;
          r.status      = ST_PUSHED;
        end
      end else begin
        // strict priority: lowest level number that holds anything
        for (int q = 0; q < NUM_LEVELS; q++) begin
          if (r.status == ST_EMPTY && fill[q] != '0) begin
            r.status    = ST_POPPED;
            r.level     = level_t'(q);
            r.payload   = slots[q][head_ptr[q]];
            head_ptr[q] = next_ptr(head_ptr[q]);
            fill[q]     = fill[q] - 1'b1;
          end
        end
      end
      awaited_results = {awaited_results, r};
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [STATUS_W-1:0] st, level_t lvl, logic [OUT_PAYLOAD_W-1:0] data);
      queue_result_t r;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing awaited, status %0d", st));
      end else begin
        r = awaited_results[0];
        awaited_results.delete(0);
        if (st !== r.status)
          report_mismatch($sformatf("status %0d, want %0d", st, r.status));
        if (lvl !== r.level)
          report_mismatch($sformatf("out_level %0d, want %0d", lvl, r.level));
        if (data !== r.payload)
          report_mismatch($sformatf("out_payload %h, want %h", data, r.payload));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int   idle_pct;
  int   stall_pct;
  logic hold_off_req;

  priority_queue_tracker tracker = new();

  tlpmq_req_if req();
  tlpmq_rsp_if rsp();

  three_level_priority_message_queue_top uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready)
        tracker.check_result(rsp.status, rsp.out_level, rsp.out_payload);
      if (req.valid && req.ready)
        tracker.note_request(req.command, req.alert_level, req.message_payload);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(logic cmd, level_t lvl, logic [IN_PAYLOAD_W-1:0] data);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid           <= 1'b1;
    req.command         <= cmd;
    req.alert_level     <= lvl;
    req.message_payload <= data;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    req.valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending_count() != 0) @(negedge clk);
  endtask

  task automatic random_traffic(int n_items);
    int     sent;
    int     kind;
    int     len;
    level_t lvl;
    logic   cmd;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(9);
      len  = $urandom_range(20, 4);
      if (kind < 3) begin
        // push run on one level: can reach full and wrap the pointers
        lvl = level_t'($urandom_range(2));
        for (int i = 0; i < len; i++) send_item(CMD_PUSH, lvl, $urandom);
      end else if (kind < 5) begin
        // pop run, usually drains to empty; level and payload are don't-care
        for (int i = 0; i < len; i++)
          send_item(CMD_POP, level_t'($urandom_range(3)), $urandom);
      end else begin
        for (int i = 0; i < len; i++) begin
          cmd = ($urandom_range(99) < 55) ? CMD_PUSH : CMD_POP;
          lvl = ($urandom_range(99) < 10) ? LVL_INVALID : level_t'($urandom_range(2));
          send_item(cmd, lvl, $urandom);
        end
      end
      sent += len;
    end
  endtask

  int idle_set[4]  = '{0, 71, 0, 7};
  int stall_set[4] = '{0, 0, 71, 7};

  initial begin
    rst                 = 1'b1;
    hold_off_req        = 1'b0;
    idle_pct            = 0;
    stall_pct           = 0;
    req.valid           = 1'b0;
    req.command         = CMD_PUSH;
    req.alert_level     = LVL_URGENT;
    req.message_payload = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // pop with all queues empty, invalid level, pushes on every level, priority order
    send_item(CMD_POP, LVL_URGENT, 32'h0);
    send_item(CMD_PUSH, LVL_INVALID, 32'h0000_0000);
    send_item(CMD_PUSH, LVL_INVALID, 32'hFFFF_FFFF);
    send_item(CMD_PUSH, LVL_BACKGROUND, 32'hFFFF_FFFF);
    send_item(CMD_PUSH, LVL_UPDATE, 32'h0000_0000);
    send_item(CMD_PUSH, LVL_URGENT, 32'h5A5A_5A5A);
    send_item(CMD_PUSH, LVL_URGENT, 32'hA5A5_A5A5);
    send_item(CMD_PUSH, LVL_BACKGROUND, 32'h0123_4567);
    for (int i = 0; i < 6; i++) send_item(CMD_POP, LVL_INVALID, 32'hFFFF_FFFF);
    pause_until_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      if (ph == 0) hold_off_req = 1'b1;
      random_traffic(PHASE_ITEMS);
      pause_until_drained();
    end

    repeat (8) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending_count() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tlpmq_pkg.sv
rtl/core/tlpmq_req_if.sv
rtl/core/tlpmq_rsp_if.sv
rtl/core/tlpmq_ctrl.sv
rtl/core/tlpmq_store.sv
rtl/core/three_level_priority_message_queue_top.sv
rtl/core/tlpmq_checker.sv
verif/tb_three_level_priority_message_queue_top.sv
